// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/jdsm_pkg.sv
// Types and constants for the joystick differential steering mixer.
package jdsm_pkg;

	localparam int XW        = 8;   // joystick axis width
	localparam int LimW      = 7;   // pivot limit width
	localparam int DriveW    = 9;   // drive output width
	localparam int QuoW      = 8;   // quotient magnitude bits (max 128)
	localparam int DivStepsPerStage = 2;
	localparam int DivStages = QuoW / DivStepsPerStage;

	localparam logic [LimW-1:0] PivotLimitReset = 7'd32;
	localparam logic [LimW-1:0] PivotLimitMin   = 7'd1;
	localparam logic signed [8:0] PremixFull    = 9'sd127;

	// Register index decoded from paddr[2]
	localparam logic RegPivotLimit = 1'b0;

	typedef struct packed {
		logic signed [16:0] ap_l;   // a * left premix
		logic signed [16:0] ap_r;   // a * right premix
		logic signed [15:0] wx;     // (lim - a) * x
		logic signed [7:0]  y;
		logic [LimW-1:0]    lim;
	} premix_t;

	typedef struct packed {
		logic            neg;
		logic [LimW-1:0] rem;
		logic [QuoW-1:0] dq;    // dividend bits shift out, quotient bits shift in
	} div_lane_t;

	typedef struct packed {
		div_lane_t       l;
		div_lane_t       r;
		logic [LimW-1:0] lim;
	} div_stage_t;

endpackage

// File: design/jdsm_premix.sv
// Stage 1: clamp |y| to the pivot limit, pick the turn premix and form the small products.
module jdsm_premix import jdsm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic signed [XW-1:0]  joy_x,
	input  logic signed [XW-1:0]  joy_y,
	input  logic [LimW-1:0]       lim,
	output logic                  out_valid,
	output premix_t               out
);

	logic [XW-1:0]      ay;
	logic [LimW-1:0]    a;
	logic [LimW-1:0]    w;
	logic signed [8:0]  x9;
	logic signed [8:0]  pl;
	logic signed [8:0]  pr;
	logic signed [8:0]  p_take;
	logic signed [8:0]  p_diff;
	premix_t            nxt;

	always_comb begin
		ay     = joy_y[XW-1] ? (~joy_y + 8'd1) : joy_y;
		a      = (ay > {1'b0, lim}) ? lim : ay[LimW-1:0];
		w      = lim - a;
		x9     = {joy_x[XW-1], joy_x};
		p_take = PremixFull + x9;   // side that loses a left turn
		p_diff = PremixFull - x9;   // side that loses a right turn
		if (!joy_y[XW-1]) begin
			pl = joy_x[XW-1] ? p_take : PremixFull;
			pr = joy_x[XW-1] ? PremixFull : p_diff;
		end else begin
			pl = joy_x[XW-1] ? PremixFull : p_diff;
			pr = joy_x[XW-1] ? p_take : PremixFull;
		end
		nxt.ap_l = $signed({1'b0, a}) * pl;
		nxt.ap_r = $signed({1'b0, a}) * pr;
		nxt.wx   = $signed({1'b0, w}) * joy_x;
		nxt.y    = joy_y;
		nxt.lim  = lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			out <= nxt;
		end
	end

endmodule

// File: design/jdsm_blend.sv
// Stage 2: scale the premix by y, add the pivot term and split into sign and dividend.
module jdsm_blend import jdsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  premix_t     in,
	output logic        out_valid,
	output div_stage_t  out
);

	logic signed [24:0] prod_l;
	logic signed [24:0] prod_r;
	logic signed [24:0] piv;
	logic signed [24:0] num_l;
	logic signed [24:0] num_r;
	logic [24:0]        mag_l;
	logic [24:0]        mag_r;
	div_stage_t         nxt;

	always_comb begin
		prod_l = in.ap_l * in.y;
		prod_r = in.ap_r * in.y;
		piv    = $signed({{2{in.wx[15]}}, in.wx, 7'd0});
		num_l  = prod_l + piv;
		num_r  = prod_r - piv;
		mag_l  = num_l[24] ? 25'(-num_l) : 25'(num_l);
		mag_r  = num_r[24] ? 25'(-num_r) : 25'(num_r);
		// |num| <= 128*128*lim, so after dropping the /128 the top bits are below lim
		nxt.l.neg = num_l[24];
		nxt.l.rem = mag_l[21:15];
		nxt.l.dq  = mag_l[14:7];
		nxt.r.neg = num_r[24];
		nxt.r.rem = mag_r[21:15];
		nxt.r.dq  = mag_r[14:7];
		nxt.lim   = in.lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			out <= nxt;
		end
	end

endmodule

// File: design/jdsm_div_step.sv
// Divider stage: restoring division steps by the pivot limit on both lanes.
module jdsm_div_step import jdsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  div_stage_t  in,
	output logic        out_valid,
	output div_stage_t  out
);

	function automatic div_lane_t step(input div_lane_t ln, input logic [LimW-1:0] d);
		logic [LimW:0] r2;
		logic          ge;
		div_lane_t     o;
		r2 = {ln.rem, ln.dq[QuoW-1]};
		ge = (r2 >= {1'b0, d});
		o.neg = ln.neg;
		o.rem = ge ? LimW'(r2 - {1'b0, d}) : r2[LimW-1:0];
		o.dq  = {ln.dq[QuoW-2:0], ge};
		return o;
	endfunction

	div_stage_t nxt;

	always_comb begin
		nxt = in;
		for (int i = 0; i < DivStepsPerStage; i++) begin
			nxt.l = step(nxt.l, in.lim);
			nxt.r = step(nxt.r, in.lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			out <= nxt;
		end
	end

endmodule

// File: design/joystick_differential_steering_mix_core.sv
// Top level of the joystick differential steering mixer: config register, pipeline, output.
//
//   channel   dir  width  contents
//   s_*       in   16     joystick sample: joy_x, joy_y
//   m_*       out  24     drive pair: left_drive, right_drive
//   apb       in   32     pivot_limit register at byte address 0
//
// One sample per cycle sustained while the drive stream is not stalled; registers from input transaction to m_tvalid:
// premix, blend, four divider stages (two quotient bits each, by the pivot limit), output.
// arst_n clears every valid bit and sets pivot_limit to 32; no clearing pass.
// Each stage holds only while it is full and the stage after it holds, so a stalled
// output register stops the pipe from the back and bubbles still close up.
`include "assert_macros.svh"

module joystick_differential_steering_mix_core import jdsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// sample stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] joy_x, [15:8] joy_y
	// drive stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [8:0] left_drive, [17:9] right_drive, [23:18] zero
);

	logic [LimW-1:0]   pivot_limit_q;
	logic [LimW-1:0]   lim_eff;
	logic              wr_en;

	logic              v1;
	premix_t           pm_s1;
	logic              en_pm;
	logic              en_bl;

	logic [DivStages:0]    dv;
	div_stage_t            ds [DivStages+1];
	logic [DivStages-1:0]  en_d;

	logic              en_out;
	logic              m_tvalid_q;
	logic [23:0]       m_tdata_q;
	logic [DriveW-1:0] left_drive;
	logic [DriveW-1:0] right_drive;

	// configuration
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == RegPivotLimit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_limit_q <= PivotLimitReset;
		end else if (wr_en) begin
			pivot_limit_q <= pwdata[LimW-1:0];
		end
	end

	assign prdata  = (paddr[2] == RegPivotLimit) ? {25'd0, pivot_limit_q} : 32'd0;
	// zero limit behaves as one
	assign lim_eff = (pivot_limit_q == '0) ? PivotLimitMin : pivot_limit_q;

	// stage enables, from the back
	assign en_out = !m_tvalid_q || m_tready;
	assign en_d[DivStages-1] = !dv[DivStages] || en_out;
	for (genvar k = 0; k < DivStages - 1; k++) begin : g_en
		assign en_d[k] = !dv[k+1] || en_d[k+1];
	end
	assign en_bl    = !dv[0] || en_d[0];
	assign en_pm    = !v1 || en_bl;
	assign s_tready = en_pm;

	jdsm_premix u_premix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_pm),
		.in_valid  (s_tvalid),
		.joy_x     ($signed(s_tdata[7:0])),
		.joy_y     ($signed(s_tdata[15:8])),
		.lim       (lim_eff),
		.out_valid (v1),
		.out       (pm_s1)
	);

	jdsm_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_bl),
		.in_valid  (v1),
		.in        (pm_s1),
		.out_valid (dv[0]),
		.out       (ds[0])
	);

	for (genvar k = 0; k < DivStages; k++) begin : g_div
		jdsm_div_step u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en_d[k]),
			.in_valid  (dv[k]),
			.in        (ds[k]),
			.out_valid (dv[k+1]),
			.out       (ds[k+1])
		);
	end

	// apply sign to the quotient
	assign left_drive  = ds[DivStages].l.neg ? DriveW'(-{1'b0, ds[DivStages].l.dq})
	                                         : {1'b0, ds[DivStages].l.dq};
	assign right_drive = ds[DivStages].r.neg ? DriveW'(-{1'b0, ds[DivStages].r.dq})
	                                         : {1'b0, ds[DivStages].r.dq};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en_out) begin
			m_tvalid_q <= dv[DivStages];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && dv[DivStages]) begin
			m_tdata_q <= {6'd0, right_drive, left_drive};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_IMPLIES(a_ready_when_out_empty, !m_tvalid_q, s_tready, "input stalled with empty output")
	`ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, v1, "accepted transaction not in stage 1")
	`ASSERT_IMPLIES(a_lim_nonzero, v1, pm_s1.lim != '0, "zero divisor in pipeline")
	`ASSERT_IMPLIES(a_rem_below_lim, dv[1], (ds[1].l.rem < ds[1].lim) && (ds[1].r.rem < ds[1].lim), "divider remainder not below limit")
	`ASSERT_IMPLIES(a_quot_range, dv[DivStages], (ds[DivStages].l.dq <= 8'd128) && (ds[DivStages].r.dq <= 8'd128), "drive magnitude above 128")

endmodule

// File: bench/tb_joystick_differential_steering_mix_core.sv
// Testbench for the joystick differential steering mixer: directed table, random samples, scoreboard.
`timescale 1ns / 100ps

module tb_joystick_differential_steering_mix_core;
	import jdsm_pkg::*;

	localparam logic [2:0] PivotLimitAddr = {RegPivotLimit, 2'b00};
	localparam int PremixTop   = 127;
	localparam int StallLimit  = 1000;
	localparam int HoldCycles  = 80;
	localparam int PhaseCount  = 6;
	localparam int PhaseItems  = 200;
	localparam int RowCount    = 25;
	localparam logic [31:0] ZeroLimitWord = 32'hFFFF_FF80;

	typedef struct packed {
		logic signed [DriveW-1:0] left;
		logic signed [DriveW-1:0] right;
	} drive_pair_t;

	typedef struct {
		logic [31:0]              cfg;
		logic signed [XW-1:0]     x;
		logic signed [XW-1:0]     y;
		bit                       known;
		logic signed [DriveW-1:0] left;
		logic signed [DriveW-1:0] right;
	} mix_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;   // [7:0] joy_x, [15:8] joy_y
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // [8:0] left_drive, [17:9] right_drive, [23:18] zero

	drive_pair_t     drive_expect[$];
	logic [LimW-1:0] pivot_lim = PivotLimitReset;
	bit              idle_on = 1'b1;
	int              fail_count = 0;
	int              drives_seen = 0;
	int              hold_left = 0;
	int              stall_cycles = 0;

	mix_row_t directed_rows [RowCount] = '{
		'{32'd32, 8'sd0,    8'sd0,    1'b1, 9'sd0,    9'sd0},
		'{32'd32, 8'sd127,  8'sd0,    1'b1, 9'sd127,  -9'sd127},
		'{32'd32, 8'sh80,   8'sd0,    1'b1, -9'sd128, 9'sd128},
		'{32'd32, 8'sd0,    8'sd127,  1'b1, 9'sd126,  9'sd126},
		'{32'd32, 8'sd0,    8'sh80,   1'b1, -9'sd127, -9'sd127},
		'{32'd32, 8'sd127,  8'sd127,  1'b0, 9'sd0,    9'sd0},
		'{32'd32, 8'sh80,   8'sd127,  1'b0, 9'sd0,    9'sd0},
		'{32'd32, 8'sd127,  8'sh80,   1'b0, 9'sd0,    9'sd0},
		'{32'd32, 8'sh80,   8'sh80,   1'b0, 9'sd0,    9'sd0},
		'{32'd32, 8'sd1,    -8'sd1,   1'b0, 9'sd0,    9'sd0},
		'{32'd32, -8'sd1,   8'sd1,    1'b0, 9'sd0,    9'sd0},
		'{32'd32, 8'sd50,   8'sd32,   1'b0, 9'sd0,    9'sd0},
		'{32'd32, 8'sd50,   8'sd33,   1'b0, 9'sd0,    9'sd0},
		'{32'd32, -8'sd50,  8'sd31,   1'b0, 9'sd0,    9'sd0},
		'{32'd32, 8'sd64,   -8'sd32,  1'b0, 9'sd0,    9'sd0},
		'{32'd32, -8'sd64,  -8'sd33,  1'b0, 9'sd0,    9'sd0},
		'{32'd32, 8'sh55,   8'shAA,   1'b0, 9'sd0,    9'sd0},
		'{32'd32, 8'shAA,   8'sh55,   1'b0, 9'sd0,    9'sd0},
		'{32'd127, 8'sd0,   8'sd127,  1'b1, 9'sd126,  9'sd126},
		'{32'd127, 8'sd100, 8'sd0,    1'b1, 9'sd100,  -9'sd100},
		'{32'd127, -8'sd77, -8'sd100, 1'b0, 9'sd0,    9'sd0},
		'{ZeroLimitWord, 8'sd100, 8'sd0,  1'b1, 9'sd100,  -9'sd100},
		'{ZeroLimitWord, 8'sd100, 8'sd1,  1'b0, 9'sd0,    9'sd0},
		'{ZeroLimitWord, 8'sh80,  -8'sd1, 1'b0, 9'sd0,    9'sd0},
		'{ZeroLimitWord, 8'sh80,  8'sd0,  1'b1, -9'sd128, 9'sd128}
	};

	joystick_differential_steering_mix_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Blend the scaled turn premix with the pivot, exact integer, truncated toward zero.
	function automatic drive_pair_t mix_drive(logic signed [XW-1:0] jx, logic signed [XW-1:0] jy,
			logic [LimW-1:0] limit_reg);
		int x, y, lim, ay, a, pl, pr;
		drive_pair_t r;
		x = int'(jx);
		y = int'(jy);
		lim = int'(limit_reg);
		if (lim == 0)
			lim = 1;
		ay = (y < 0) ? -y : y;
		a = (ay > lim) ? lim : ay;
		if (y >= 0) begin
			pl = (x >= 0) ? PremixTop : PremixTop + x;
			pr = (x >= 0) ? PremixTop - x : PremixTop;
		end else begin
			pl = (x >= 0) ? PremixTop - x : PremixTop;
			pr = (x >= 0) ? PremixTop : PremixTop + x;
		end
		r.left  = DriveW'((a * pl * y + (lim - a) * x * 128) / (128 * lim));
		r.right = DriveW'((a * pr * y - (lim - a) * x * 128) / (128 * lim));
		return r;
	endfunction

	function automatic logic [XW-1:0] axis_edge();
		unique case ($urandom_range(4))
			0: return 8'h80;
			1: return 8'hFF;
			2: return 8'h00;
			3: return 8'h01;
			default: return 8'h7F;
		endcase
	endfunction

	task automatic send_sample(input logic [XW-1:0] jx, input logic [XW-1:0] jy,
			input bit known, input drive_pair_t given);
		while (idle_on && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {jy, jx};
		do @(posedge clk); while (!s_tready);
		drive_expect.push_back(known ? given : mix_drive(jx, jy, pivot_lim));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (drive_expect.size() != 0)
			@(posedge clk);
	endtask

	task automatic read_cfg(output logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PivotLimitAddr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		v = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_cfg(input logic [31:0] v);
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PivotLimitAddr;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pivot_lim = v[LimW-1:0];
		// go straight into the read-back setup cycle
		read_cfg(rd);
		if (rd[LimW-1:0] !== v[LimW-1:0]) begin
			$display("%0t pivot_limit readback: expected %0d, actual %0d",
				$time, v[LimW-1:0], rd[LimW-1:0]);
			fail_count++;
		end
	endtask

	// Drive output side: check each transaction, stall at random, hold off twice.
	always @(posedge clk) begin
		drive_pair_t want;
		drive_pair_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.left = $signed(m_tdata[8:0]);
				got.right = $signed(m_tdata[17:9]);
				if (drive_expect.size() == 0) begin
					$display("%0t unexpected drive: expected none, actual left %0d right %0d",
						$time, got.left, got.right);
					fail_count++;
				end else begin
					want = drive_expect.pop_front();
					if (got.left !== want.left)
						$display("%0t left_drive: expected %0d, actual %0d",
							$time, want.left, got.left);
					if (got.right !== want.right)
						$display("%0t right_drive: expected %0d, actual %0d",
							$time, want.right, got.right);
					if (got !== want)
						fail_count++;
				end
				drives_seen++;
				if (drives_seen == 300 || drives_seen == 700)
					hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= !(idle_on && $urandom_range(99) < 11);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= StallLimit) begin
				$display("%0t watchdog: no transaction for %0d cycles", $time, StallLimit);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] rd;
		logic [31:0] cfg_now;
		logic [31:0] cfg_word;
		logic [XW-1:0] jx, jy;
		int eff, t, pick;
		drive_pair_t given;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_cfg(rd);
		if (rd[LimW-1:0] !== PivotLimitReset) begin
			$display("%0t pivot_limit after reset: expected %0d, actual %0d",
				$time, PivotLimitReset, rd[LimW-1:0]);
			fail_count++;
		end

		cfg_now = 32'd32;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].cfg != cfg_now) begin
				drain();
				write_cfg(directed_rows[i].cfg);
				cfg_now = directed_rows[i].cfg;
			end
			given.left = directed_rows[i].left;
			given.right = directed_rows[i].right;
			send_sample(directed_rows[i].x, directed_rows[i].y, directed_rows[i].known, given);
		end

		for (int ph = 0; ph < PhaseCount; ph++) begin
			unique case (ph)
				0: cfg_word = 32'd1;
				1: cfg_word = 32'd127;
				3: cfg_word = ZeroLimitWord;
				default: cfg_word = ($urandom & 32'hFFFF_FF80) | $urandom_range(2, 126);
			endcase
			drain();
			write_cfg(cfg_word);
			// keep one whole phase free of idle cycles
			idle_on = (ph != 2);
			eff = (pivot_lim == '0) ? 1 : int'(pivot_lim);
			for (int i = 0; i < PhaseItems; i++) begin
				pick = $urandom_range(99);
				jx = 8'($urandom_range(255));
				if (pick < 40) begin
					t = $urandom_range(0, 2 * eff) - eff;
					jy = t[XW-1:0];
				end else if (pick < 50) begin
					jx = axis_edge();
					jy = axis_edge();
				end else begin
					jy = 8'($urandom_range(255));
				end
				send_sample(jx, jy, 1'b0, '0);
			end
		end
		idle_on = 1'b1;

		drain();
		repeat (12) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
